// ----- rtl/core/sic_pkg.sv -----
`timescale 1ns / 1ps

package sic_pkg;

	// Sequencer states
	typedef enum logic [4:0] {
		S_IDLE,
		S_RANGE,
		S_RDIV,
		S_SQ,
		S_SENS,
		S_PLO,
		S_PHI,
		S_PSUM,
		S_UDIV,
		S_ROM0,
		S_ROM1,
		S_INTERP,
		S_ATAN,
		S_COEF,
		S_SCALE,
		S_MAGS,
		S_SLEW
	} sic_state_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SENS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MODE  = 2'd2;

	// Speed breakpoints, Q8.8 mph
	localparam logic [15:0] TRANS_Q     = 16'd3840;
	localparam logic [15:0] NORMAL_Q    = 16'd7680;
	localparam logic [15:0] LOW_SPEED_Q = 16'd256;
	// Denominator once the divide factor reaches 4.5
	localparam logic [15:0] DEN_FULL    = 16'd34560;

	// 900 * 2/pi in Q16
	localparam logic [31:0] COEFF_K = 32'd37549364;

	// Atan argument is Q0.32 and never above 2^-9
	localparam int ATAN_U_LOG = 23;
	localparam int ATAN_W     = 24;

	// Shared divider geometry
	localparam int DIV_RW = 51;
	localparam int DIV_LW = 24;
	localparam int DIV_CW = 5;
	localparam logic [DIV_CW-1:0] RANGE_STEPS = 5'd15;
	localparam logic [DIV_CW-1:0] U_STEPS     = 5'd24;
	// Top part of 2^63 when 24 quotient bits are developed
	localparam logic [DIV_RW-1:0] U_NUM_HI = 51'(64'h0000_0080_0000_0000);

	typedef struct packed {
		logic                start;
		logic [DIV_CW-1:0]   steps;
		logic [DIV_RW-1:0]   num_hi;
		logic [DIV_LW-1:0]   num_lo;
		logic [DIV_RW-1:0]   den;
	} sic_div_req_t;

	// atan(a) ~ a - a^3/3 with a in Q0.32, evaluated at elaboration
	function automatic logic [ATAN_W-1:0] atan_entry(input int unsigned k,
			input int unsigned tb);
		logic [63:0] a;
		logic [63:0] t;
		logic [63:0] c;
		a = 64'(k) << (ATAN_U_LOG - tb);
		t = (a * a) >> 16;
		c = (t * a) >> 48;
		return ATAN_W'(a - c / 64'd3);
	endfunction

endpackage

// ----- rtl/core/sic_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sic_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sic_pkg::sic_div_req_t           req,
	output logic                            done,
	output logic [sic_pkg::DIV_LW-1:0]      quot
);

	logic [sic_pkg::DIV_RW-1:0] rem_q;
	logic [sic_pkg::DIV_RW-1:0] den_q;
	logic [sic_pkg::DIV_LW-1:0] nlo_q;
	logic [sic_pkg::DIV_LW-1:0] quot_q;
	logic [sic_pkg::DIV_CW-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [sic_pkg::DIV_RW:0]   trial;
	logic [sic_pkg::DIV_RW:0]   sub;
	logic                       ge;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, nlo_q[sic_pkg::DIV_LW-1]};
		sub   = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == sic_pkg::DIV_CW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - sic_pkg::DIV_CW'(1);
				if (cnt_q == sic_pkg::DIV_CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num_hi;
			nlo_q  <= req.num_lo;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? sub[sic_pkg::DIV_RW-1:0] : trial[sic_pkg::DIV_RW-1:0];
			nlo_q  <= {nlo_q[sic_pkg::DIV_LW-2:0], 1'b0};
			quot_q <= {quot_q[sic_pkg::DIV_LW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- rtl/core/steering_input_conditioner.sv -----
`timescale 1ns / 1ps

// Channel  | handshake                  | word
// ---------+----------------------------+--------------------------------------------
// item     | item_valid / item_ready    | left_demand, right_demand, speed_mph, time_step
// result   | result_valid / result_ready| left_out, right_out
// config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// How long one word takes depends on whether the range divide and the speed
// scaling apply; the bit-serial divider (15 or 24 steps) and the shared 32x32
// multiplier, used once per sequencer step, set that time.
// item_ready is high only while the sequencer is idle; a finished word sits in the
// result register while the next item is taken, and the sequencer waits at its last
// step only if that register is still full. Reset centers the position and clears the
// configuration. cfg_ready is always high.
module steering_input_conditioner #(
	parameter int ATAN_TABLE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [14:0] left_demand,
	input  logic [14:0] right_demand,
	input  logic [15:0] speed_mph,
	input  logic [15:0] time_step,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [14:0] left_out,
	output logic [14:0] right_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [sic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int SEG   = sic_pkg::ATAN_U_LOG - ATAN_TABLE_BITS;
	localparam int ROM_N = 1 << ATAN_TABLE_BITS;
	localparam int AW    = sic_pkg::ATAN_W;

	sic_pkg::sic_state_t state_q, state_d;

	// Configuration and kept position
	logic               rle_q;
	logic [15:0]        sens_q;
	logic               wheel_q;
	logic signed [15:0] pos_q;

	// Item working registers
	logic [15:0] s_q;
	logic [15:0] dt_q;
	logic        neg_q;
	logic [14:0] mag_q;
	logic [24:0] w_q;
	logic [6:0]  ahi_q;
	logic [56:0] plo_q;
	logic [AW-1:0] u_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] rom_rd_q;
	logic [AW-1:0] atan_q;
	logic [63:0] prod_q;

	// Result register
	logic        out_valid_q;
	logic [14:0] left_q;
	logic [14:0] right_q;

	// Shared multiplier operands
	logic [31:0] mul_a;
	logic [31:0] mul_b;

	sic_pkg::sic_div_req_t div_req;
	logic                  div_done;
	logic [AW-1:0]         div_quot;

	logic [ATAN_TABLE_BITS:0] rom_addr;
	logic [AW-1:0]            atan_tab [ROM_N+1];

	logic                     item_acc;
	logic                     slot_free;
	logic [22:0]              s80;
	logic [15:0]              den;
	logic [27:0]              rnum;
	logic [63:0]              p_sum;
	logic [ATAN_TABLE_BITS:0] u_idx;
	logic [SEG-1:0]           u_frac;
	logic                     u_edge;

	logic [17:0]        step;
	logic signed [19:0] val_s;
	logic signed [19:0] pos_s;
	logic signed [19:0] step_s;
	logic signed [19:0] up_s;
	logic signed [19:0] dn_s;
	logic signed [19:0] nxt_s;
	logic signed [19:0] lim_s;

	// Atan table, constant
	for (genvar k = 0; k <= ROM_N; k++) begin : g_tab
		assign atan_tab[k] = sic_pkg::atan_entry(k, ATAN_TABLE_BITS);
	end

	sic_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign item_ready   = (state_q == sic_pkg::S_IDLE);
	assign item_acc     = item_valid && item_ready;
	assign slot_free    = !out_valid_q || result_ready;
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign left_out     = left_q;
	assign right_out    = right_q;

	// Datapath helpers
	always_comb begin
		s80    = 23'({s_q, 6'b0}) + 23'({s_q, 4'b0});
		den    = (s_q >= sic_pkg::NORMAL_Q) ? sic_pkg::DEN_FULL :
			sic_pkg::NORMAL_Q + 16'({(s_q - sic_pkg::TRANS_Q), 3'b0})
			- (s_q - sic_pkg::TRANS_Q);
		rnum   = 28'({mag_q, 13'b0}) - 28'({mag_q, 9'b0});
		p_sum  = 64'(plo_q) + {prod_q[31:0], 32'b0};
		u_idx  = u_q[AW-1:SEG];
		u_frac = u_q[SEG-1:0];
		u_edge = u_idx[ATAN_TABLE_BITS];
	end

	// Slew toward the demand (wheel mode takes the demand directly), then clamp
	always_comb begin
		step   = 18'((19'({dt_q, 2'b0}) + 19'(dt_q)) >> 1);
		val_s  = neg_q ? -$signed({5'b0, mag_q}) : $signed({5'b0, mag_q});
		pos_s  = 20'(pos_q);
		step_s = $signed({2'b0, step});
		up_s   = val_s - pos_s;
		dn_s   = pos_s - val_s;
		if (wheel_q)
			nxt_s = val_s;
		else if (val_s > pos_s)
			nxt_s = (up_s <= step_s) ? val_s : pos_s + step_s;
		else
			nxt_s = (dn_s <= step_s) ? val_s : pos_s - step_s;
		if (nxt_s > 20'sd32767)
			lim_s = 20'sd32767;
		else if (nxt_s < -20'sd32767)
			lim_s = -20'sd32767;
		else
			lim_s = nxt_s;
	end

	// Sequencer: next state, multiplier operands, divider start, table address
	always_comb begin
		state_d  = state_q;
		mul_a    = '0;
		mul_b    = '0;
		div_req  = '0;
		rom_addr = u_idx;
		unique case (state_q)
			sic_pkg::S_IDLE: begin
				if (item_valid)
					state_d = sic_pkg::S_RANGE;
			end
			sic_pkg::S_RANGE: begin
				if (rle_q && (s_q >= sic_pkg::TRANS_Q)) begin
					div_req.start  = 1'b1;
					div_req.steps  = sic_pkg::RANGE_STEPS;
					div_req.num_hi = sic_pkg::DIV_RW'(rnum[27:15]);
					div_req.num_lo = {rnum[14:0], 9'b0};
					div_req.den    = sic_pkg::DIV_RW'(den);
					state_d = sic_pkg::S_RDIV;
				end else begin
					state_d = sic_pkg::S_SQ;
				end
			end
			sic_pkg::S_RDIV: begin
				if (div_done)
					state_d = sic_pkg::S_SQ;
			end
			sic_pkg::S_SQ: begin
				if ((sens_q != '0) && (s_q > sic_pkg::LOW_SPEED_Q)) begin
					mul_a   = 32'(mag_q);
					mul_b   = 32'(mag_q);
					state_d = sic_pkg::S_SENS;
				end else begin
					state_d = sic_pkg::S_SLEW;
				end
			end
			sic_pkg::S_SENS: begin
				mul_a   = 32'(s80);
				mul_b   = 32'(sens_q);
				state_d = sic_pkg::S_PLO;
			end
			sic_pkg::S_PLO: begin
				mul_a   = prod_q[31:0];
				mul_b   = 32'(w_q);
				state_d = sic_pkg::S_PHI;
			end
			sic_pkg::S_PHI: begin
				mul_a   = 32'(ahi_q);
				mul_b   = 32'(w_q);
				state_d = sic_pkg::S_PSUM;
			end
			sic_pkg::S_PSUM: begin
				if (p_sum[63:53] != '0) begin
					div_req.start  = 1'b1;
					div_req.steps  = sic_pkg::U_STEPS;
					div_req.num_hi = sic_pkg::U_NUM_HI;
					div_req.num_lo = '0;
					div_req.den    = p_sum[63:13];
					state_d = sic_pkg::S_UDIV;
				end else begin
					state_d = sic_pkg::S_SLEW;
				end
			end
			sic_pkg::S_UDIV: begin
				if (div_done)
					state_d = sic_pkg::S_ROM0;
			end
			sic_pkg::S_ROM0: begin
				state_d = sic_pkg::S_ROM1;
			end
			sic_pkg::S_ROM1: begin
				// top edge of the table: no next entry
				rom_addr = u_edge ? u_idx : u_idx + 1'b1;
				state_d  = sic_pkg::S_INTERP;
			end
			sic_pkg::S_INTERP: begin
				mul_a   = 32'(rom_rd_q - base_q);
				mul_b   = 32'(u_frac);
				state_d = sic_pkg::S_ATAN;
			end
			sic_pkg::S_ATAN: begin
				state_d = sic_pkg::S_COEF;
			end
			sic_pkg::S_COEF: begin
				mul_a   = 32'(atan_q);
				mul_b   = sic_pkg::COEFF_K;
				state_d = sic_pkg::S_SCALE;
			end
			sic_pkg::S_SCALE: begin
				// coefficient of one or more leaves the magnitude alone
				if (prod_q[63:48] == '0) begin
					mul_a   = 32'(mag_q);
					mul_b   = 32'(prod_q[47:32]);
					state_d = sic_pkg::S_MAGS;
				end else begin
					state_d = sic_pkg::S_SLEW;
				end
			end
			sic_pkg::S_MAGS: begin
				state_d = sic_pkg::S_SLEW;
			end
			sic_pkg::S_SLEW: begin
				if (slot_free)
					state_d = sic_pkg::S_IDLE;
			end
			default: begin
				state_d = sic_pkg::S_IDLE;
			end
		endcase
	end

	// State, configuration, position, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sic_pkg::S_IDLE;
			rle_q       <= 1'b0;
			sens_q      <= '0;
			wheel_q     <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sic_pkg::CFG_RANGE_LIMIT: rle_q   <= cfg_data[0];
					sic_pkg::CFG_SPEED_SENS:  sens_q  <= cfg_data;
					sic_pkg::CFG_WHEEL_MODE:  wheel_q <= cfg_data[0];
					default: ;
				endcase
			end
			if ((state_q == sic_pkg::S_SLEW) && slot_free) begin
				pos_q       <= lim_s[15:0];
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		prod_q   <= mul_a * mul_b;
		rom_rd_q <= atan_tab[rom_addr];
		if (item_acc) begin
			neg_q <= left_demand > right_demand;
			mag_q <= (left_demand > right_demand) ? left_demand : right_demand;
			s_q   <= speed_mph;
			dt_q  <= time_step;
		end
		unique case (state_q)
			sic_pkg::S_RDIV: if (div_done) mag_q <= div_quot[14:0];
			sic_pkg::S_SENS: w_q <= 25'((31'h4000_0000 - 31'(prod_q[29:0])) >> 6);
			sic_pkg::S_PLO:  ahi_q <= prod_q[38:32];
			sic_pkg::S_PHI:  plo_q <= prod_q[56:0];
			sic_pkg::S_UDIV: if (div_done) u_q <= div_quot;
			sic_pkg::S_ROM1: base_q <= rom_rd_q;
			sic_pkg::S_ATAN: atan_q <= base_q + AW'(prod_q >> SEG);
			sic_pkg::S_MAGS: mag_q <= prod_q[30:16];
			sic_pkg::S_SLEW: begin
				if (slot_free) begin
					if (lim_s < 0) begin
						left_q  <= 15'(-lim_s);
						right_q <= '0;
					end else begin
						left_q  <= '0;
						right_q <= lim_s[14:0];
					end
				end
			end
			default: ;
		endcase
	end

	// Checks
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == sic_pkg::S_RDIV || state_q == sic_pkg::S_UDIV))
		else $error("divider finished outside a wait step");

	a_result_from_slew: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == sic_pkg::S_SLEW))
		else $error("result word raised without a slew step");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (left_q == '0 || right_q == '0))
		else $error("both sides nonzero");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 16'sh8000)
		else $error("steering position out of range");

endmodule

// ----- tb/steering_input_conditioner_test.sv -----
`timescale 1ns / 1ps

module steering_input_conditioner_test;

	localparam int TBL_BITS  = 8;
	localparam int TBL_SEGS  = 1 << TBL_BITS;
	localparam int SEG_SHIFT = 23 - TBL_BITS;
	localparam int WATCHDOG  = 2000;
	localparam int TAIL_WAIT = 80;
	localparam int RND_PHASES = 7;
	localparam int RND_PER_PHASE = 250;

	// Speed breakpoints (Q8.8 mph) and scale constants
	localparam logic [15:0] RAMP_START = 16'd3840;
	localparam logic [15:0] RAMP_END   = 16'd7680;
	localparam logic [15:0] SLOW_LIMIT = 16'd256;
	localparam logic [63:0] FULL_DEN   = 64'd34560;
	localparam logic [63:0] ATAN_GAIN  = 64'd37549364;
	localparam int          POS_MAX    = 32767;

	typedef struct packed {
		logic [14:0] left;
		logic [14:0] right;
	} steer_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [14:0] left_demand = '0;
	logic [14:0] right_demand = '0;
	logic [15:0] speed_mph = '0;
	logic [15:0] time_step = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [14:0] left_out;
	logic [14:0] right_out;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [sic_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Predictor copy of the registers and the kept position
	logic        range_en;
	logic [15:0] sens_gain;
	logic        wheel_on;
	int          position;
	logic [63:0] atan_lut [0:TBL_SEGS];

	steer_out_t  steer_out_q[$];
	steer_out_t  want;
	int          flaws = 0;
	int          idle_cycles = 0;
	int          sink_stall = 0;
	bit          sink_calm = 1'b0;
	bit          src_calm = 1'b0;

	steering_input_conditioner #(
		.ATAN_TABLE_BITS(TBL_BITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.left_demand (left_demand),
		.right_demand(right_demand),
		.speed_mph   (speed_mph),
		.time_step   (time_step),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.left_out    (left_out),
		.right_out   (right_out),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected steering output for one demand word; advances the kept position
	function automatic steer_out_t condition_steer(input logic [14:0] l, input logic [14:0] r,
			input logic [15:0] s, input logic [15:0] dt);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] den;
		logic [63:0] w;
		logic [63:0] p;
		logic [63:0] u;
		logic [63:0] idx;
		logic [63:0] fr;
		logic [63:0] at;
		logic [63:0] coeff;
		int          val;
		int          pos;
		int          step;
		steer_out_t  o;
		neg = l > r;
		mag = neg ? 64'(l) : 64'(r);
		// range limit: divide factor ramps from 1 to 4.5 across 15..30 mph
		if (range_en && s >= RAMP_START) begin
			den = (s >= RAMP_END) ? FULL_DEN : 64'(RAMP_END) + 64'd7 * 64'(s - RAMP_START);
			mag = (mag * 64'(RAMP_END)) / den;
		end
		// speed sensitivity: coefficient from atan(1/x), applied only when below 1
		if (sens_gain != 16'd0 && s > SLOW_LIMIT) begin
			w = ((64'd1 << 30) - mag * mag) >> 6;
			p = 64'(s) * 64'd80 * 64'(sens_gain) * w;
			if (p >= (64'd1 << 53)) begin
				u = (64'd1 << 63) / (p >> 13);
				idx = u >> SEG_SHIFT;
				fr = u & ((64'd1 << SEG_SHIFT) - 64'd1);
				if (idx >= TBL_SEGS)
					at = atan_lut[TBL_SEGS];
				else
					at = atan_lut[idx] + (((atan_lut[idx + 1] - atan_lut[idx]) * fr) >> SEG_SHIFT);
				coeff = (at * ATAN_GAIN) >> 32;
				if (coeff < 64'd65536)
					mag = (mag * coeff) >> 16;
			end
		end
		val = neg ? -int'(mag) : int'(mag);
		// slew toward the demand unless a wheel drives it directly
		if (!wheel_on) begin
			pos = position;
			step = (5 * int'(dt)) >>> 1;
			if (val > pos) begin
				if (val - pos <= step)
					pos = val;
				else
					pos += step;
			end else begin
				if (pos - val <= step)
					pos = val;
				else
					pos -= step;
			end
			if (pos > POS_MAX)
				pos = POS_MAX;
			if (pos < -POS_MAX)
				pos = -POS_MAX;
			val = pos;
		end
		position = val;
		if (val < 0) begin
			o.left = 15'(-val);
			o.right = '0;
		end else begin
			o.left = '0;
			o.right = 15'(val);
		end
		return o;
	endfunction

	// Send one demand word after a random gap; entered and left at a falling edge
	task automatic feed_demand(input logic [14:0] l, input logic [14:0] r,
			input logic [15:0] s, input logic [15:0] dt);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 3);
		if ($urandom_range(0, 49) == 0)
			src_calm = !src_calm;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		left_demand <= l;
		right_demand <= r;
		speed_mph <= s;
		time_step <= dt;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		steer_out_q = {steer_out_q, condition_steer(l, r, s, dt)};
		@(negedge clk);
	endtask

	// Stop sending and wait for every outstanding word
	task automatic drain_steer();
		item_valid <= 1'b0;
		while (steer_out_q.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [sic_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sic_pkg::CFG_RANGE_LIMIT: range_en = data[0];
			sic_pkg::CFG_SPEED_SENS:  sens_gain = data;
			sic_pkg::CFG_WHEEL_MODE:  wheel_on = data[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Registers change only with the block idle
	task automatic set_config(input logic rng, input logic [15:0] sens, input logic wheel);
		drain_steer();
		write_reg(sic_pkg::CFG_RANGE_LIMIT, {15'd0, rng});
		write_reg(sic_pkg::CFG_SPEED_SENS, sens);
		write_reg(sic_pkg::CFG_WHEEL_MODE, {15'd0, wheel});
		cfg_valid <= 1'b0;
	endtask

	// Side selection, ties, extremes, slew and zero time step
	task automatic test_demand_split();
		set_config(1'b0, 16'd0, 1'b0);
		feed_demand(15'd0, 15'd0, 16'd0, 16'd0);
		feed_demand(15'd1000, 15'd1000, 16'd0, 16'hFFFF);
		feed_demand(15'h7FFF, 15'd0, 16'd0, 16'hFFFF);
		feed_demand(15'd0, 15'h7FFF, 16'd0, 16'hFFFF);
		feed_demand(15'd0, 15'd0, 16'd0, 16'd0);
		feed_demand(15'd0, 15'h7FFF, 16'd0, 16'd0);
		feed_demand(15'h7FFF, 15'h7FFE, 16'd0, 16'd1);
		feed_demand(15'h5555, 15'h2AAA, 16'hAAAA, 16'h5555);
	endtask

	// Wheel bypasses the slew
	task automatic test_wheel_mode();
		set_config(1'b0, 16'd0, 1'b1);
		feed_demand(15'h7FFF, 15'd0, 16'd0, 16'd0);
		feed_demand(15'd0, 15'h7FFF, 16'd0, 16'd0);
		feed_demand(15'd12345, 15'd12345, 16'd0, 16'd3);
	endtask

	// Range divide across the speed ramp
	task automatic test_range_limit();
		set_config(1'b1, 16'd0, 1'b1);
		feed_demand(15'h7FFF, 15'd0, 16'd3839, 16'd0);
		feed_demand(15'd0, 15'h7FFF, 16'd3840, 16'd0);
		feed_demand(15'h7FFF, 15'd0, 16'd5760, 16'd0);
		feed_demand(15'd0, 15'h7FFF, 16'd7679, 16'd0);
		feed_demand(15'h7FFF, 15'd0, 16'd7680, 16'd0);
		feed_demand(15'd0, 15'h7FFF, 16'hFFFF, 16'd0);
	endtask

	// Speed scaling: slow cutoff, weak and full gain, then with slew
	task automatic test_speed_scaling();
		set_config(1'b0, 16'hFFFF, 1'b1);
		feed_demand(15'd0, 15'h7FFF, 16'd256, 16'd0);
		feed_demand(15'd0, 15'h4000, 16'd257, 16'd0);
		feed_demand(15'h4000, 15'd0, 16'hFFFF, 16'd0);
		feed_demand(15'd0, 15'd0, 16'hFFFF, 16'd0);
		set_config(1'b0, 16'd1, 1'b1);
		feed_demand(15'd0, 15'd20000, 16'hFFFF, 16'd0);
		set_config(1'b1, 16'd4096, 1'b0);
		feed_demand(15'd30000, 15'd0, 16'd6000, 16'd1092);
		feed_demand(15'd0, 15'd30000, 16'd12000, 16'd1092);
	endtask

	// Random demand words over several register settings
	task automatic test_random();
		logic [14:0] l;
		logic [14:0] r;
		logic [15:0] s;
		logic [15:0] dt;
		logic [15:0] sens;
		for (int ph = 0; ph < RND_PHASES; ph++) begin
			sens = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
			case (ph)
				0: set_config(1'b0, 16'd0, 1'b0);
				1: set_config(1'b1, 16'd0, 1'b0);
				2: set_config(1'b1, 16'hFFFF, 1'b0);
				3: set_config(1'b0, 16'($urandom), 1'b1);
				4: set_config(1'b1, 16'd1, 1'b1);
				default: set_config(1'($urandom), sens, $urandom_range(0, 3) == 0);
			endcase
			for (int n = 0; n < RND_PER_PHASE; n++) begin
				l = 15'($urandom);
				r = 15'($urandom);
				case ($urandom_range(0, 7))
					0: r = l;
					1: l = 15'h7FFF;
					2: l = '0;
					3: r = '0;
					default: ;
				endcase
				case ($urandom_range(0, 5))
					0: s = 16'($urandom_range(0, 256));
					1: s = 16'($urandom_range(3800, 7720));
					2: s = 16'($urandom);
					3: s = 16'hFFFF;
					default: s = 16'($urandom_range(257, 20000));
				endcase
				case ($urandom_range(0, 5))
					0: dt = 16'd0;
					1: dt = 16'($urandom);
					default: dt = 16'($urandom_range(0, 2000));
				endcase
				feed_demand(l, r, s, dt);
				// let the pipeline run dry once mid-stream
				if (ph == 2 && n == RND_PER_PHASE / 2)
					drain_steer();
			end
		end
	endtask

	// Check each returned word against the oldest prediction; draw the next stall
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (steer_out_q.size() == 0) begin
				$error("unexpected word: left_out %0d right_out %0d", left_out, right_out);
				flaws++;
			end else begin
				want = steer_out_q.pop_front();
				if (left_out !== want.left) begin
					$error("left_out: expected %0d, got %0d", want.left, left_out);
					flaws++;
				end
				if (right_out !== want.right) begin
					$error("right_out: expected %0d, got %0d", want.right, right_out);
					flaws++;
				end
			end
			sink_stall = sink_calm ? 0 : $urandom_range(0, 3);
			if ($urandom_range(0, 39) == 0)
				sink_calm = !sink_calm;
		end
	end

	always @(negedge clk) begin
		if (sink_stall > 0) begin
			result_ready <= 1'b0;
			sink_stall--;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Watchdog on cycles with no accepted word on any channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [63:0] a;
		logic [63:0] t;
		logic [63:0] c;
		// atan table: a - a^3/3 on Q0.32 points
		for (int k = 0; k <= TBL_SEGS; k++) begin
			a = 64'(k) << SEG_SHIFT;
			t = (a * a) >> 16;
			c = (t * a) >> 48;
			atan_lut[k] = a - c / 64'd3;
		end
		range_en = 1'b0;
		sens_gain = '0;
		wheel_on = 1'b0;
		position = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_demand_split();
		test_wheel_mode();
		test_range_limit();
		test_speed_scaling();
		test_random();
		drain_steer();
		repeat (TAIL_WAIT) @(negedge clk);
		if (flaws == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
